// ----- src/rpt_pkg.sv -----
`timescale 1ns / 1ps
// Package for the radix page table walk block: sizes, payload structs,
// walk state and register index codes. No dependencies.
package rpt_pkg;

  localparam int RADIX_BITS  = 9;
  localparam int PAGE_BITS   = 12;
  localparam int TABLE_NODES = 64;
  localparam int DATA_PAGES  = 4096;

  localparam int ADDR_W  = 39;
  localparam int OUT_W   = 12;
  localparam int DPL_W   = 12;
  localparam int NL_W    = 6;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 1;

  localparam int NODE_W  = $clog2(TABLE_NODES);
  localparam int PAGE_W  = $clog2(DATA_PAGES);
  localparam int ENTRY_W = (NODE_W > PAGE_W) ? NODE_W : PAGE_W;
  localparam int MEM_AW  = NODE_W + RADIX_BITS;
  localparam int MEM_DEPTH = TABLE_NODES * (1 << RADIX_BITS);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DATA_PAGE_LIMIT = 1'd0;
  localparam cfg_idx_t REG_NODE_LIMIT      = 1'd1;

  typedef logic [1:0] lvl_t;
  localparam lvl_t LVL_TOP  = 2'd0;
  localparam lvl_t LVL_MID  = 2'd1;
  localparam lvl_t LVL_LEAF = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } walk_state_t;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] byte_address;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] data_page;
    logic [OUT_W-1:0] page_offset;
    logic             allocated_any;
  } out_item_t;

  typedef struct packed {
    logic              node_ok;
    logic [NODE_W-1:0] node_num;
    logic              page_ok;
    logic [PAGE_W-1:0] page_num;
  } pool_status_t;

  // Zero-extend or truncate a table entry to the output page field.
  function automatic logic [OUT_W-1:0] fit_out(input logic [ENTRY_W-1:0] e);
    logic [ENTRY_W+OUT_W-1:0] tmp;
    tmp = {{OUT_W{1'b0}}, e};
    return tmp[OUT_W-1:0];
  endfunction

endpackage

// ----- src/rpt_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module rpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/rpt_pool.sv -----
`timescale 1ns / 1ps
// Bump allocators for table nodes and data pages, with their limit registers.
// Depends on rpt_pkg.
module rpt_pool (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  rpt_pkg::cfg_idx_t       cfg_index,
  input  logic [rpt_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                    take_node,
  input  logic                    take_page,
  output rpt_pkg::pool_status_t   status
);
  import rpt_pkg::*;

  logic [DPL_W-1:0]  page_limit_r, page_limit_nxt;
  logic [NL_W-1:0]   node_limit_r, node_limit_nxt;
  logic [NODE_W:0]   next_node_r, next_node_nxt;
  logic [PAGE_W:0]   next_page_r, next_page_nxt;

  always_comb begin
    page_limit_nxt = page_limit_r;
    node_limit_nxt = node_limit_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DATA_PAGE_LIMIT: page_limit_nxt = cfg_wdata[DPL_W-1:0];
        REG_NODE_LIMIT:      node_limit_nxt = cfg_wdata[NL_W-1:0];
        default: ;
      endcase
    end
    next_node_nxt = take_node ? next_node_r + 1'b1 : next_node_r;
    next_page_nxt = take_page ? next_page_r + 1'b1 : next_page_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_limit_r <= '1;
      node_limit_r <= '1;
      next_node_r  <= (NODE_W+1)'(1);
      next_page_r  <= (PAGE_W+1)'(1);
    end else begin
      page_limit_r <= page_limit_nxt;
      node_limit_r <= node_limit_nxt;
      next_node_r  <= next_node_nxt;
      next_page_r  <= next_page_nxt;
    end
  end

  assign status.node_ok  = (32'(next_node_r) <= 32'(node_limit_r)) &&
                           (32'(next_node_r) < 32'(TABLE_NODES));
  assign status.node_num = next_node_r[NODE_W-1:0];
  assign status.page_ok  = (32'(next_page_r) <= 32'(page_limit_r)) &&
                           (32'(next_page_r) < 32'(DATA_PAGES));
  assign status.page_num = next_page_r[PAGE_W-1:0];

endmodule

// ----- src/radix_page_table_walk_alloc.sv -----
`timescale 1ns / 1ps
// Top level of the three-level radix page table walk with allocation.
// Depends on rpt_pkg, rpt_ram and rpt_pool.
//
// After reset the block sweeps the whole entry memory to zero, one entry a
// cycle (32768 entries at the default sizes); busy stays high during the
// sweep, while configuration writes are taken as usual. An item is a
// transfer at a clock edge with start high and busy low. A walk reads one
// table entry per cycle from a single memory with a registered read: it
// reads the top-level, middle-level and leaf entries in that order and
// ends at the leaf entry (hit, allocation or failure there) or at the
// first entry it cannot fill. An item that finds no root (or cannot make
// one) is answered without a walk. A missing entry is written back in the
// same cycle as the read of the next level is issued. The result is shown
// for exactly one cycle with out_valid high, in the cycle after the walk
// ends; the receiver cannot stall it, and the next item may be transferred
// in that same cycle.
module radix_page_table_walk_alloc (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  rpt_pkg::in_item_t         in_item,
  output logic                      out_valid,
  output rpt_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  rpt_pkg::cfg_idx_t         cfg_index,
  input  logic [rpt_pkg::CFG_W-1:0] cfg_wdata
);
  import rpt_pkg::*;

  walk_state_t       state_r, state_nxt;
  lvl_t              lvl_r, lvl_nxt;
  logic [NODE_W-1:0] root_r, root_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              alloc_r, alloc_nxt;
  logic              made_r, made_nxt;
  logic [MEM_AW-1:0] clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic               mem_we;
  logic [MEM_AW-1:0]  mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  logic               take_node, take_page;
  pool_status_t       pool;

  // Scratch for the combinational block.
  logic [NODE_W-1:0]    root_sel;
  logic [RADIX_BITS-1:0] idx_cur, idx_next;
  logic [ENTRY_W-1:0]   child;
  logic                 found;

  rpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rpt_pool u_pool (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .take_node (take_node),
    .take_page (take_page),
    .status    (pool)
  );

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    root_nxt      = root_r;
    cur_nxt       = cur_r;
    addr_nxt      = addr_r;
    alloc_nxt     = alloc_r;
    made_nxt      = made_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    take_node     = 1'b0;
    take_page     = 1'b0;
    root_sel      = root_r;
    child         = mem_rdata;
    found         = 1'b0;

    // Index used at the current level, and the one for the level below.
    case (lvl_r)
      LVL_TOP: begin
        idx_cur  = addr_r[PAGE_BITS+2*RADIX_BITS +: RADIX_BITS];
        idx_next = addr_r[PAGE_BITS+RADIX_BITS +: RADIX_BITS];
      end
      LVL_MID: begin
        idx_cur  = addr_r[PAGE_BITS+RADIX_BITS +: RADIX_BITS];
        idx_next = addr_r[PAGE_BITS +: RADIX_BITS];
      end
      default: begin
        idx_cur  = addr_r[PAGE_BITS +: RADIX_BITS];
        idx_next = addr_r[PAGE_BITS +: RADIX_BITS];
      end
    endcase

    case (state_r)
      ST_CLEAR: begin
        // Sweep every entry to empty.
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == MEM_AW'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          addr_nxt  = in_item.byte_address;
          alloc_nxt = in_item.func;
          made_nxt  = 1'b0;
          if (root_r == '0 && in_item.func && pool.node_ok) begin
            take_node = 1'b1;
            root_sel  = pool.node_num;
            root_nxt  = pool.node_num;
            made_nxt  = 1'b1;
          end
          if (root_sel == '0) begin
            // No root: miss or failure straight away.
            out_valid_nxt         = 1'b1;
            out_nxt.hit           = 1'b0;
            out_nxt.data_page     = '0;
            out_nxt.page_offset   = in_item.byte_address[OUT_W-1:0];
            out_nxt.allocated_any = 1'b0;
          end else begin
            // Issue the read of the top-level entry.
            mem_raddr = {root_sel,
                         in_item.byte_address[PAGE_BITS+2*RADIX_BITS +: RADIX_BITS]};
            cur_nxt   = root_sel;
            lvl_nxt   = LVL_TOP;
            state_nxt = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        found = (mem_rdata != '0);
        if (!found && alloc_r) begin
          if (lvl_r != LVL_LEAF) begin
            if (pool.node_ok) begin
              take_node = 1'b1;
              child     = ENTRY_W'(pool.node_num);
              found     = 1'b1;
            end
          end else if (pool.page_ok) begin
            take_page = 1'b1;
            child     = ENTRY_W'(pool.page_num);
            found     = 1'b1;
          end
          if (found) begin
            // Link the fresh node or page into the parent entry.
            mem_we    = 1'b1;
            mem_waddr = {cur_r, idx_cur};
            mem_wdata = child;
            made_nxt  = 1'b1;
          end
        end

        if (!found || lvl_r == LVL_LEAF) begin
          out_valid_nxt         = 1'b1;
          out_nxt.hit           = found;
          out_nxt.data_page     = found ? fit_out(child) : '0;
          out_nxt.page_offset   = addr_r[OUT_W-1:0];
          out_nxt.allocated_any = made_nxt;
          state_nxt             = ST_IDLE;
        end else begin
          // Advance to the next level; its node is empty if just made.
          mem_raddr = {child[NODE_W-1:0], idx_next};
          cur_nxt   = child[NODE_W-1:0];
          lvl_nxt   = lvl_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      lvl_r       <= LVL_TOP;
      root_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      made_r      <= 1'b0;
      alloc_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      root_r      <= root_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      made_r      <= made_nxt;
      alloc_r     <= alloc_nxt;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    addr_r <= addr_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
